[rtl/ringtone_note_parser_defines.svh]
// Assertion macros shared by the RTL of the ringtone note parser.
// RTNP_ASSERT_SAME checks a consequent in the same cycle as its antecedent.
// RTNP_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef RINGTONE_NOTE_PARSER_DEFINES_SVH
`define RINGTONE_NOTE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define RTNP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define RTNP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTNP_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define RTNP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/rtnp_pkg.sv]
package rtnp_pkg;

    // Parse phases within one note.
    localparam logic [1:0] PH_DUR    = 2'd0;
    localparam logic [1:0] PH_LETTER = 2'd1;
    localparam logic [1:0] PH_MODS   = 2'd2;
    localparam logic [1:0] PH_OCT    = 2'd3;

    // Progress through the duration digits.
    localparam logic [1:0] FD_NONE  = 2'd0;
    localparam logic [1:0] FD_ONE   = 2'd1;
    localparam logic [1:0] FD_THREE = 2'd2;
    localparam logic [1:0] FD_DONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEFAULT_DURATION = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_OCTAVE   = 2'd1;
    localparam logic [1:0] CFG_BEAT_TICKS       = 2'd2;

    // Characters of the note grammar.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef logic [10:0] pitch_t;

    // Octave-six frequencies of the natural notes; a pause gives zero.
    function automatic pitch_t natural_pitch(input logic [7:0] c);
        case (c)
            CH_A: natural_pitch = 11'd1760;
            CH_B: natural_pitch = 11'd1976;
            CH_C: natural_pitch = 11'd1047;
            CH_D: natural_pitch = 11'd1175;
            CH_E: natural_pitch = 11'd1319;
            CH_F: natural_pitch = 11'd1397;
            CH_G: natural_pitch = 11'd1568;
            default: natural_pitch = 11'd0;
        endcase
    endfunction

    // Raise a natural by a semitone; e, b and a pause have no sharp.
    function automatic pitch_t sharpen(input pitch_t p);
        case (p)
            11'd1760: sharpen = 11'd1865;
            11'd1047: sharpen = 11'd1109;
            11'd1175: sharpen = 11'd1245;
            11'd1397: sharpen = 11'd1480;
            11'd1568: sharpen = 11'd1661;
            default:  sharpen = p;
        endcase
    endfunction

    // Position of the highest set bit; zero and one both give zero.
    function automatic logic [2:0] dur_shift(input logic [5:0] d);
        if (d[5])      dur_shift = 3'd5;
        else if (d[4]) dur_shift = 3'd4;
        else if (d[3]) dur_shift = 3'd3;
        else if (d[2]) dur_shift = 3'd2;
        else if (d[1]) dur_shift = 3'd1;
        else           dur_shift = 3'd0;
    endfunction

endpackage

[rtl/ringtone_note_parser.sv]
// Ringtone note parser. Characters of the note section of a ringtone text
// arrive one per transaction on the s_ channel (tdata carries the character,
// tlast marks the last character of the song). A note is an optional
// duration (1, 2, 4, 8, 16 or 32), a letter a to g or p for a pause, an
// optional sharp, an optional dot and an optional octave digit 4 to 7. A
// note is completed by a comma or by the last character, and then one
// transaction leaves on the m_ channel with the tone frequency in hertz
// (zero for a pause), the length in timer ticks (the beat divided by the
// duration, half again if dotted) and tlast set when the note ends the
// song. Spaces are skipped, upper case letters count as lower case, and
// anything outside the grammar is ignored. Missing duration and octave take
// the values of the configuration registers, which the user must have written
// over the cfg_ channel only while the block is idle; the block itself does
// not enforce this. The block takes one character per clock cycle unless
// back-pressure on the m_ channel stalls it; a character passes an input
// register and one stage of decode, table lookup and shifting into the
// result register. Back-pressure on the m_ channel stalls the input only
// when both registers are full.
`include "ringtone_note_parser_defines.svh"

module ringtone_note_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Character input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic        s_tlast,   // text_end
    // Note output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] tone_hz, [28:12] length_ticks, rest zero
    output logic        m_tlast    // song_done
);

    // Configuration registers.
    logic [5:0]  default_duration_reg;
    logic [2:0]  default_octave_reg;
    logic [15:0] beat_ticks_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_end_reg;

    // Note being assembled.
    logic [1:0]      parse_phase_reg, parse_phase_next;
    logic [5:0]      pend_dur_reg, pend_dur_next;
    rtnp_pkg::pitch_t pend_pitch_reg, pend_pitch_next;
    logic [2:0]      pend_oct_reg, pend_oct_next;
    logic            pend_dot_reg, pend_dot_next;
    logic [1:0]      first_digit_reg, first_digit_next;

    // Result register.
    logic        out_valid_reg;
    logic [11:0] tone_reg, tone_next;
    logic [16:0] len_reg, len_next;
    logic        done_reg;

    // Character decode and state after taking it.
    logic [7:0]       ch;
    logic             is_comma;
    logic             emit_now;
    logic             advance;
    logic [1:0]       ph_t;
    logic [5:0]       dur_t;
    rtnp_pkg::pitch_t pitch_t_v;
    logic [2:0]       oct_t;
    logic             dot_t;
    logic [1:0]       fd_t;
    logic [2:0]       oct_sel;
    logic [5:0]       dur_sel;
    logic [15:0]      len_base;

    assign cfg_ready = 1'b1;

    // The stage moves when the result register is free or being emptied.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, len_reg, tone_reg};
    assign m_tlast  = done_reg;

    always_comb begin
        if (in_char_reg >= rtnp_pkg::CH_UP_A && in_char_reg <= rtnp_pkg::CH_UP_Z) begin
            ch = in_char_reg | rtnp_pkg::CASE_BIT;
        end else begin
            ch = in_char_reg;
        end
    end

    assign is_comma = (in_char_reg == rtnp_pkg::CH_COMMA);
    assign emit_now = is_comma || in_end_reg;

    // Apply one character to the note in progress.
    always_comb begin
        ph_t      = parse_phase_reg;
        dur_t     = pend_dur_reg;
        pitch_t_v = pend_pitch_reg;
        oct_t     = pend_oct_reg;
        dot_t     = pend_dot_reg;
        fd_t      = first_digit_reg;
        if (!is_comma && in_char_reg != rtnp_pkg::CH_SPACE) begin
            if (parse_phase_reg == rtnp_pkg::PH_DUR) begin
                if ((ch >= rtnp_pkg::CH_A && ch <= rtnp_pkg::CH_G) || ch == rtnp_pkg::CH_P) begin
                    pitch_t_v = rtnp_pkg::natural_pitch(ch);
                    ph_t      = rtnp_pkg::PH_LETTER;
                end else if (ch >= rtnp_pkg::CH_0 && ch <= rtnp_pkg::CH_9) begin
                    case (first_digit_reg)
                        rtnp_pkg::FD_NONE: begin
                            if (ch == rtnp_pkg::CH_1) begin
                                dur_t = 6'd1;
                                fd_t  = rtnp_pkg::FD_ONE;
                            end else if (ch == rtnp_pkg::CH_3) begin
                                fd_t = rtnp_pkg::FD_THREE;
                            end else if (ch == rtnp_pkg::CH_2 || ch == rtnp_pkg::CH_4
                                         || ch == rtnp_pkg::CH_8) begin
                                dur_t = 6'(ch - rtnp_pkg::CH_0);
                                fd_t  = rtnp_pkg::FD_DONE;
                            end
                        end
                        rtnp_pkg::FD_ONE: begin
                            if (ch == rtnp_pkg::CH_6) dur_t = 6'd16;
                            fd_t = rtnp_pkg::FD_DONE;
                        end
                        rtnp_pkg::FD_THREE: begin
                            if (ch == rtnp_pkg::CH_2) dur_t = 6'd32;
                            fd_t = rtnp_pkg::FD_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (ch == rtnp_pkg::CH_SHARP && parse_phase_reg == rtnp_pkg::PH_LETTER) begin
                pitch_t_v = rtnp_pkg::sharpen(pend_pitch_reg);
                ph_t      = rtnp_pkg::PH_MODS;
            end else if (ch == rtnp_pkg::CH_DOT) begin
                dot_t = 1'b1;
                if (parse_phase_reg == rtnp_pkg::PH_LETTER) ph_t = rtnp_pkg::PH_MODS;
            end else if (ch >= rtnp_pkg::CH_4 && ch <= rtnp_pkg::CH_7
                         && parse_phase_reg != rtnp_pkg::PH_OCT) begin
                oct_t = 3'(ch - rtnp_pkg::CH_0);
                ph_t  = rtnp_pkg::PH_OCT;
            end
        end
    end

    // A finished note starts the next one from scratch.
    always_comb begin
        if (emit_now) begin
            parse_phase_next = rtnp_pkg::PH_DUR;
            pend_dur_next    = '0;
            pend_pitch_next  = '0;
            pend_oct_next    = '0;
            pend_dot_next    = 1'b0;
            first_digit_next = rtnp_pkg::FD_NONE;
        end else begin
            parse_phase_next = ph_t;
            pend_dur_next    = dur_t;
            pend_pitch_next  = pitch_t_v;
            pend_oct_next    = oct_t;
            pend_dot_next    = dot_t;
            first_digit_next = fd_t;
        end
    end

    // Tone: octave-six value scaled by octave, with octaves below four
    // saturated to four.
    always_comb begin
        oct_sel = (oct_t != 3'd0) ? oct_t : default_octave_reg;
        case (oct_sel)
            3'd7:    tone_next = {pitch_t_v, 1'b0};
            3'd6:    tone_next = {1'b0, pitch_t_v};
            3'd5:    tone_next = {2'b00, pitch_t_v[10:1]};
            default: tone_next = {3'b000, pitch_t_v[10:2]};
        endcase
    end

    // Length: beat divided by the duration, plus half again when dotted.
    always_comb begin
        dur_sel  = (dur_t != 6'd0) ? dur_t : default_duration_reg;
        len_base = beat_ticks_reg >> rtnp_pkg::dur_shift(dur_sel);
        if (dot_t) begin
            len_next = {1'b0, len_base} + {2'b00, len_base[15:1]};
        end else begin
            len_next = {1'b0, len_base};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_duration_reg <= 6'd4;
            default_octave_reg   <= 3'd6;
            beat_ticks_reg       <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rtnp_pkg::CFG_DEFAULT_DURATION: default_duration_reg <= cfg_data[5:0];
                rtnp_pkg::CFG_DEFAULT_OCTAVE:   default_octave_reg   <= cfg_data[2:0];
                rtnp_pkg::CFG_BEAT_TICKS:       beat_ticks_reg       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase_reg <= rtnp_pkg::PH_DUR;
            pend_dur_reg    <= '0;
            pend_pitch_reg  <= '0;
            pend_oct_reg    <= '0;
            pend_dot_reg    <= 1'b0;
            first_digit_reg <= rtnp_pkg::FD_NONE;
        end else if (in_valid_reg && advance) begin
            parse_phase_reg <= parse_phase_next;
            pend_dur_reg    <= pend_dur_next;
            pend_pitch_reg  <= pend_pitch_next;
            pend_oct_reg    <= pend_oct_next;
            pend_dot_reg    <= pend_dot_next;
            first_digit_reg <= first_digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && emit_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && emit_now) begin
            tone_reg <= tone_next;
            len_reg  <= len_next;
            done_reg <= in_end_reg;
        end
    end

    `RTNP_ASSERT_NEXT(a_emit_gives_result, aclk, aresetn,
        in_valid_reg && advance && emit_now, out_valid_reg,
        "completed note did not reach the result register")
    `RTNP_ASSERT_NEXT(a_emit_clears_note, aclk, aresetn,
        in_valid_reg && advance && emit_now,
        parse_phase_reg == rtnp_pkg::PH_DUR && pend_dur_reg == 6'd0 && pend_oct_reg == 3'd0,
        "note state not cleared after a result")
    `RTNP_ASSERT_NEXT(a_stall_keeps_char, aclk, aresetn,
        in_valid_reg && !advance, in_valid_reg && $stable(in_char_reg),
        "character lost from the input register while stalled")
    `RTNP_ASSERT_SAME(a_octave_range, aclk, aresetn,
        1'b1, pend_oct_reg == 3'd0 || pend_oct_reg >= 3'd4,
        "pending octave outside four to seven")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Self-checking bench for the ringtone note parser.
//
// Characters go in on the s_ channel one transaction at a time, and every
// accepted character is also fed to a behavioural predictor kept in this
// module. Whenever the predictor finishes a note, the expected tone, length
// and end-of-song flag are queued. The m_ side pops the oldest entry for each
// accepted transaction and compares it field by field.
//
// The run begins with a short scripted phase under the reset values of the
// registers. It then moves through several register settings, the extremes
// among them. Each setting is followed by randomly built notes: mostly
// well-formed notes with random content, with stray spaces, noise bytes,
// misplaced modifiers and malformed durations mixed in.
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_CHARS   = 154;
    localparam int NUM_SETTINGS  = 7;
    localparam int SHOW_LIMIT    = 10;
    localparam logic [2:0] LETTER_REST = 3'd7;

    // One finished note, in the order of the fields on the m_ channel.
    typedef struct packed {
        logic [11:0] hz;
        logic [16:0] len;
        logic        done;
    } note_t;

    // One line of the scripted phase. Where typed is set, want is the note
    // that the line must produce, worked out by hand.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic       typed;
        note_t      want;
    } script_row_t;

    localparam note_t NO_NOTE = '0;

    // Reset values: duration 4, octave 6, 1000 ticks per beat.
    localparam script_row_t SCRIPT [0:25] = '{
        '{rtnp_pkg::CH_A,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_COMMA, 1'b0, 1'b1, '{12'd1760, 17'd250, 1'b0}},
        // Thirty-second note, sharp on b has no effect, dotted, octave 7.
        '{rtnp_pkg::CH_3,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_2,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_B,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_SHARP, 1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_DOT,   1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_7,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_COMMA, 1'b0, 1'b1, '{12'd3952, 17'd46, 1'b0}},
        // Whole-beat pause given in upper case.
        '{rtnp_pkg::CH_1,     1'b0, 1'b0, NO_NOTE},
        '{8'h50,              1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_COMMA, 1'b0, 1'b1, '{12'd0, 17'd1000, 1'b0}},
        // Sixteenth c sharp in octave 4, dot after the octave, song ends.
        '{rtnp_pkg::CH_1,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_6,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_C,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_SHARP, 1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_4,     1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_DOT,   1'b1, 1'b1, '{12'd277, 17'd93, 1'b1}},
        // A comma with no letter gives a pause of the default length.
        '{rtnp_pkg::CH_COMMA, 1'b0, 1'b1, '{12'd0, 17'd250, 1'b0}},
        // Octave 5 with an unknown byte in the middle.
        '{rtnp_pkg::CH_G,     1'b0, 1'b0, NO_NOTE},
        '{8'h35,              1'b0, 1'b0, NO_NOTE},
        '{8'hFF,              1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_COMMA, 1'b0, 1'b0, NO_NOTE},
        // Upper case E with a sharp keeps its natural pitch.
        '{8'h45,              1'b0, 1'b0, NO_NOTE},
        '{rtnp_pkg::CH_SHARP, 1'b0, 1'b0, NO_NOTE},
        // A space that carries the end of the song still closes the note.
        '{rtnp_pkg::CH_SPACE, 1'b1, 1'b1, '{12'd1319, 17'd250, 1'b1}}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = rtnp_pkg::CFG_DEFAULT_DURATION;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] text_char
    logic        s_tlast   = 1'b0; // text_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [11:0] tone_hz, [28:12] length_ticks
    logic        m_tlast;          // song_done

    // Register copies held by the predictor.
    logic [5:0]  def_dur  = 6'd4;
    logic [2:0]  def_oct  = 3'd6;
    logic [15:0] beat_len = 16'd1000;

    // Parser state of the note being assembled.
    logic [1:0]  cur_phase  = rtnp_pkg::PH_DUR;
    logic [5:0]  cur_dur    = '0;
    logic [2:0]  cur_letter = LETTER_REST;
    logic        cur_sharp  = 1'b0;
    logic [2:0]  cur_oct    = '0;
    logic        cur_dot    = 1'b0;
    logic [1:0]  cur_digits = rtnp_pkg::FD_NONE;

    note_t       notes_due[$];
    int          fault_count = 0;
    int          chars_sent  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          ready_hold  = 0;

    ringtone_note_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Octave-six frequency of a letter (0 is a, 6 is g); the rest code and
    // anything unknown give silence. Sharps on e and b fall back to natural.
    function automatic logic [10:0] octave6_hz(input logic [2:0] letter, input logic sharp);
        case (letter)
            3'd0:    octave6_hz = sharp ? 11'd1865 : 11'd1760;
            3'd1:    octave6_hz = 11'd1976;
            3'd2:    octave6_hz = sharp ? 11'd1109 : 11'd1047;
            3'd3:    octave6_hz = sharp ? 11'd1245 : 11'd1175;
            3'd4:    octave6_hz = 11'd1319;
            3'd5:    octave6_hz = sharp ? 11'd1480 : 11'd1397;
            3'd6:    octave6_hz = sharp ? 11'd1661 : 11'd1568;
            default: octave6_hz = 11'd0;
        endcase
    endfunction

    // Fold one character into the note being assembled.
    function automatic void absorb_char(input logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c >= rtnp_pkg::CH_UP_A && c <= rtnp_pkg::CH_UP_Z) c = c | rtnp_pkg::CASE_BIT;
        if (cur_phase == rtnp_pkg::PH_DUR) begin
            if ((c >= rtnp_pkg::CH_A && c <= rtnp_pkg::CH_G) || c == rtnp_pkg::CH_P) begin
                cur_letter = (c == rtnp_pkg::CH_P) ? LETTER_REST : 3'(c - rtnp_pkg::CH_A);
                cur_phase  = rtnp_pkg::PH_LETTER;
            end else if (c >= rtnp_pkg::CH_0 && c <= rtnp_pkg::CH_9) begin
                case (cur_digits)
                    rtnp_pkg::FD_NONE: begin
                        if (c == rtnp_pkg::CH_1) begin
                            cur_dur    = 6'd1;
                            cur_digits = rtnp_pkg::FD_ONE;
                        end else if (c == rtnp_pkg::CH_3) begin
                            cur_digits = rtnp_pkg::FD_THREE;
                        end else if (c == rtnp_pkg::CH_2 || c == rtnp_pkg::CH_4
                                     || c == rtnp_pkg::CH_8) begin
                            cur_dur    = 6'(c - rtnp_pkg::CH_0);
                            cur_digits = rtnp_pkg::FD_DONE;
                        end
                    end
                    rtnp_pkg::FD_ONE: begin
                        if (c == rtnp_pkg::CH_6) cur_dur = 6'd16;
                        cur_digits = rtnp_pkg::FD_DONE;
                    end
                    rtnp_pkg::FD_THREE: begin
                        if (c == rtnp_pkg::CH_2) cur_dur = 6'd32;
                        cur_digits = rtnp_pkg::FD_DONE;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (c == rtnp_pkg::CH_SHARP && cur_phase == rtnp_pkg::PH_LETTER) begin
            cur_sharp = 1'b1;
            cur_phase = rtnp_pkg::PH_MODS;
        end else if (c == rtnp_pkg::CH_DOT) begin
            cur_dot = 1'b1;
            if (cur_phase == rtnp_pkg::PH_LETTER) cur_phase = rtnp_pkg::PH_MODS;
        end else if (c >= rtnp_pkg::CH_4 && c <= rtnp_pkg::CH_7
                     && cur_phase != rtnp_pkg::PH_OCT) begin
            cur_oct   = 3'(c - rtnp_pkg::CH_0);
            cur_phase = rtnp_pkg::PH_OCT;
        end
    endfunction

    // Turn the assembled note into its tone and length, then start afresh.
    function automatic note_t close_note(input logic done);
        note_t      nt;
        logic [2:0] octv;
        logic [5:0] durv;
        logic [2:0] sh;
        octv = (cur_oct != 0) ? cur_oct : def_oct;
        if (octv < 3'd4) octv = 3'd4;
        durv = (cur_dur != 0) ? cur_dur : def_dur;
        sh = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (durv[i]) sh = 3'(i);
        end
        nt.hz = {1'b0, octave6_hz(cur_letter, cur_sharp)};
        if (octv == 3'd7) nt.hz = nt.hz << 1;
        else nt.hz = nt.hz >> (3'd6 - octv);
        nt.len = {1'b0, beat_len} >> sh;
        if (cur_dot) nt.len = nt.len + (nt.len >> 1);
        nt.done    = done;
        cur_phase  = rtnp_pkg::PH_DUR;
        cur_dur    = '0;
        cur_letter = LETTER_REST;
        cur_sharp  = 1'b0;
        cur_oct    = '0;
        cur_dot    = 1'b0;
        cur_digits = rtnp_pkg::FD_NONE;
        return nt;
    endfunction

    // Predict the effect of one accepted character; returns 1 when a note
    // is finished by it.
    function automatic bit parse_char(input logic [7:0] ch, input logic is_last,
                                      output note_t nt);
        if (ch == rtnp_pkg::CH_COMMA) begin
            nt = close_note(is_last);
            return 1'b1;
        end
        if (ch != rtnp_pkg::CH_SPACE) absorb_char(ch);
        if (is_last) begin
            nt = close_note(1'b1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Present one character and wait for its transaction. The sender works
    // in bursts: when a burst runs out, it may drop tvalid before the next
    // one. A typed note, where given, replaces the predicted one in the
    // queue of expected notes.
    task automatic put_char(input logic [7:0] ch, input logic is_last,
                            input logic typed, input note_t want);
        note_t nt;
        int    gap;
        bit    got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        chars_sent++;
        got = parse_char(ch, is_last, nt);
        if (typed) notes_due.push_back(want);
        else if (got) notes_due.push_back(nt);
    endtask

    // Build one note from random parts and send it. Most notes are well
    // formed; now and then a part is malformed or out of place. When
    // end_song is set the note closes the song by one of the three ways
    // the grammar allows.
    task automatic play_note(input bit end_song);
        logic [7:0] txt[$];
        logic [7:0] ch;
        int         k;
        int         tail;
        bit         sharp;
        bit         dot;
        bit         mark;
        case ($urandom_range(0, 11))
            0: txt.push_back(rtnp_pkg::CH_1);
            1: txt.push_back(rtnp_pkg::CH_2);
            2: txt.push_back(rtnp_pkg::CH_4);
            3: txt.push_back(rtnp_pkg::CH_8);
            4: begin
                txt.push_back(rtnp_pkg::CH_1);
                txt.push_back(rtnp_pkg::CH_6);
            end
            5: begin
                txt.push_back(rtnp_pkg::CH_3);
                txt.push_back(rtnp_pkg::CH_2);
            end
            6: begin
                // Any digit or digit pair, mostly outside the grammar.
                txt.push_back(8'(rtnp_pkg::CH_0 + $urandom_range(0, 9)));
                if ($urandom_range(0, 1) != 0)
                    txt.push_back(8'(rtnp_pkg::CH_0 + $urandom_range(0, 9)));
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 9) != 0) begin
            k  = $urandom_range(0, 7);
            ch = (k == 7) ? rtnp_pkg::CH_P : 8'(rtnp_pkg::CH_A + k);
            if ($urandom_range(0, 1) != 0) ch = ch & ~rtnp_pkg::CASE_BIT;
            txt.push_back(ch);
            // Occasionally a second letter, which must be ignored.
            if ($urandom_range(0, 19) == 0)
                txt.push_back(8'(rtnp_pkg::CH_A + $urandom_range(0, 6)));
        end
        sharp = ($urandom_range(0, 4) < 2);
        dot   = ($urandom_range(0, 3) == 0);
        if (sharp && dot && $urandom_range(0, 4) == 0) begin
            // Sharp after the dot comes too late to count.
            txt.push_back(rtnp_pkg::CH_DOT);
            txt.push_back(rtnp_pkg::CH_SHARP);
        end else begin
            if (sharp) txt.push_back(rtnp_pkg::CH_SHARP);
            if (dot) txt.push_back(rtnp_pkg::CH_DOT);
        end
        case ($urandom_range(0, 5))
            0, 1, 2: txt.push_back(8'(rtnp_pkg::CH_4 + $urandom_range(0, 3)));
            3:       txt.push_back(8'(rtnp_pkg::CH_0 + $urandom_range(0, 9)));
            default: begin
            end
        endcase
        if ($urandom_range(0, 9) == 0) txt.push_back(rtnp_pkg::CH_DOT);

        // Closing: 0 marks the final character itself, 1 a comma, 2 a space.
        tail = $urandom_range(0, 3);
        if (tail == 3 || (tail == 0 && txt.size() == 0)) tail = 1;

        foreach (txt[i]) begin
            if ($urandom_range(0, 11) == 0) put_char(rtnp_pkg::CH_SPACE, 1'b0, 1'b0, NO_NOTE);
            if ($urandom_range(0, 19) == 0)
                put_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_NOTE);
            // A stray end mark now and then cuts a note short mid-song.
            mark = (end_song && tail == 0 && i == txt.size() - 1) ||
                   ($urandom_range(0, 59) == 0);
            put_char(txt[i], mark, 1'b0, NO_NOTE);
        end
        if (!end_song) put_char(rtnp_pkg::CH_COMMA, 1'b0, 1'b0, NO_NOTE);
        else if (tail == 1) put_char(rtnp_pkg::CH_COMMA, 1'b1, 1'b0, NO_NOTE);
        else if (tail == 2) put_char(rtnp_pkg::CH_SPACE, 1'b1, 1'b0, NO_NOTE);
    endtask

    // Write all three registers back to back, keeping cfg_valid high
    // between them, and mirror each write in the predictor.
    task automatic load_settings(input logic [5:0] dur, input logic [2:0] oct,
                                 input logic [15:0] beat);
        logic [1:0]  regs [3];
        logic [15:0] vals [3];
        regs[0] = rtnp_pkg::CFG_DEFAULT_DURATION;
        regs[1] = rtnp_pkg::CFG_DEFAULT_OCTAVE;
        regs[2] = rtnp_pkg::CFG_BEAT_TICKS;
        vals[0] = {10'd0, dur};
        vals[1] = {13'd0, oct};
        vals[2] = beat;
        for (int r = 0; r < 3; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            do @(posedge aclk); while (!cfg_ready);
            case (regs[r])
                rtnp_pkg::CFG_DEFAULT_DURATION: def_dur  = vals[r][5:0];
                rtnp_pkg::CFG_DEFAULT_OCTAVE:   def_oct  = vals[r][2:0];
                default:                        beat_len = vals[r];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every expected note, then let the pipeline drain
    // in case a character without a note is still inside.
    task automatic settle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (notes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (SCRIPT[i])
            put_char(SCRIPT[i].ch, SCRIPT[i].is_last, SCRIPT[i].typed, SCRIPT[i].want);
        settle();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0: load_settings(6'd1, 3'd4, 16'hFFFF);
                1: load_settings(6'd32, 3'd7, 16'd1);
                // Zero duration counts as a whole note, octave 0 saturates.
                2: load_settings(6'd0, 3'd0, 16'd1000);
                // Highest bit of 63 is 32, octave 3 saturates to 4.
                3: load_settings(6'd63, 3'd3, 16'($urandom_range(1, 65535)));
                4: load_settings(6'd12, 3'd5, 16'($urandom_range(1, 65535)));
                default: load_settings(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                                       16'($urandom_range(1, 65535)));
            endcase
            begin
                int start_count;
                start_count = chars_sent;
                while (chars_sent - start_count < PHASE_CHARS)
                    play_note($urandom_range(0, 9) == 0);
            end
            play_note(1'b1);
            settle();
        end

        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // The receiver alternates ready and stalled stretches of random length;
    // some ready stretches are long enough to run with no back-pressure.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_tready) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 7);
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 12);
        end
    end

    // Compare every note transaction with the oldest expected note.
    always @(posedge aclk) begin
        note_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (notes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("unexpected note: hz %0d len %0d done %0d",
                             m_tdata[11:0], m_tdata[28:12], m_tlast);
            end else begin
                want = notes_due.pop_front();
                if (m_tdata[11:0] !== want.hz || m_tdata[28:12] !== want.len ||
                    m_tlast !== want.done) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("note mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.hz, want.len, want.done,
                                 m_tdata[11:0], m_tdata[28:12], m_tlast);
                end
            end
        end
    end

    // Watchdog: a hang, or a note that never arrives, ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
